### rtl/core/imhdy_pkg.sv
package imhdy_pkg;

  // Default number format: signed Q16.16 in a 32-bit word.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Ratio of specific heats register: unsigned, FRAC_BITS fraction bits.
  localparam int              GAMMA_W     = 19;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd109227;

endpackage

### rtl/core/imhdy_div.sv
module imhdy_div #(
  parameter int DATA_WIDTH = imhdy_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = imhdy_pkg::FRAC_BITS_DEF,
  parameter int LANES      = 1,
  parameter int SIDE_W     = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [LANES-1:0][DATA_WIDTH-1:0]    in_num,
  input  logic [DATA_WIDTH-1:0]               in_den,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_vld,
  output logic [LANES-1:0][DATA_WIDTH-1:0]    out_quo,
  output logic [SIDE_W-1:0]                   out_side
);

  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DW    = W + F;
  localparam int STEPS = DW;

  localparam logic [W:0] VMAXU = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] VMINU = {2'b01, {(W-1){1'b0}}};

  typedef struct packed {
    logic          neg;
    logic          over;
    logic [W-1:0]  rem;
    logic [DW-1:0] dvd;
    logic [W:0]    quo;
  } lane_t;

  typedef struct packed {
    logic                   vld;
    logic [W-1:0]           den;
    logic [SIDE_W-1:0]      side;
    lane_t [LANES-1:0]      lane;
  } dst_t;

  dst_t                         st_r   [STEPS+1];
  dst_t                         st_nxt [STEPS+1];
  logic                         vld_r;
  logic [LANES-1:0][W-1:0]      quo_r;
  logic [LANES-1:0][W-1:0]      quo_nxt;
  logic [SIDE_W-1:0]            side_r;

  // Set-up stage and one restoring quotient bit per stage after it.
  always_comb begin
    logic [W-1:0] mag;
    logic [W:0]   r2;
    logic         ge;
    st_nxt[0].vld  = in_vld;
    st_nxt[0].den  = in_den;
    st_nxt[0].side = in_side;
    for (int l = 0; l < LANES; l++) begin
      mag = in_num[l][W-1] ? (~in_num[l] + 1'b1) : in_num[l];
      st_nxt[0].lane[l].neg  = in_num[l][W-1];
      st_nxt[0].lane[l].over = 1'b0;
      st_nxt[0].lane[l].rem  = '0;
      st_nxt[0].lane[l].dvd  = {mag, {F{1'b0}}};
      st_nxt[0].lane[l].quo  = '0;
    end
    for (int k = 1; k <= STEPS; k++) begin
      st_nxt[k] = st_r[k-1];
      for (int l = 0; l < LANES; l++) begin
        r2 = {st_r[k-1].lane[l].rem, st_r[k-1].lane[l].dvd[DW-1]};
        ge = (r2 >= {1'b0, st_r[k-1].den});
        st_nxt[k].lane[l].rem  = ge ? W'(r2 - {1'b0, st_r[k-1].den}) : r2[W-1:0];
        st_nxt[k].lane[l].dvd  = {st_r[k-1].lane[l].dvd[DW-2:0], 1'b0};
        st_nxt[k].lane[l].over = st_r[k-1].lane[l].over | st_r[k-1].lane[l].quo[W];
        st_nxt[k].lane[l].quo  = {st_r[k-1].lane[l].quo[W-1:0], ge};
      end
    end
  end

  // Stage registers: only the valid bits need a reset.
  always_ff @(posedge clk) begin
    for (int k = 0; k <= STEPS; k++) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Apply the sign and saturate to the signed word range.
  always_comb begin
    logic [W:0] q;
    logic       sat;
    for (int l = 0; l < LANES; l++) begin
      q = st_r[STEPS].lane[l].quo;
      if (!st_r[STEPS].lane[l].neg) begin
        sat        = st_r[STEPS].lane[l].over | (q > VMAXU);
        quo_nxt[l] = sat ? VMAXU[W-1:0] : q[W-1:0];
      end else begin
        sat        = st_r[STEPS].lane[l].over | (q > VMINU);
        quo_nxt[l] = sat ? VMINU[W-1:0] : (~q[W-1:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r  <= st_r[STEPS].vld;
      quo_r  <= quo_nxt;
      side_r <= st_r[STEPS].side;
    end
  end

  assign out_vld  = vld_r;
  assign out_quo  = quo_r;
  assign out_side = side_r;

endmodule

### rtl/core/ideal_mhd_y_flux_top.sv
// Ideal MHD flux along the third component for one grid point per word. The
// block takes one word in every clock cycle unless the result side stalls,
// and returns one result word for each, in order (Q16.16 by default). The
// restoring divider resolves one quotient bit per stage for the eleven
// divisions by density and forms most of the pipeline. A stall on the
// result side holds the whole pipeline. Gamma is written through the cfg port
// and should only change while no words are in flight.
module ideal_mhd_y_flux_top #(
  parameter int DATA_WIDTH = imhdy_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = imhdy_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [imhdy_pkg::GAMMA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  in_density,
  input  logic signed [DATA_WIDTH-1:0]  in_momentum_x,
  input  logic signed [DATA_WIDTH-1:0]  in_momentum_y,
  input  logic signed [DATA_WIDTH-1:0]  in_momentum_z,
  input  logic signed [DATA_WIDTH-1:0]  in_field_x,
  input  logic signed [DATA_WIDTH-1:0]  in_field_y,
  input  logic signed [DATA_WIDTH-1:0]  in_field_z,
  input  logic signed [DATA_WIDTH-1:0]  in_total_energy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  out_flux_mass,
  output logic signed [DATA_WIDTH-1:0]  out_flux_momentum_x,
  output logic signed [DATA_WIDTH-1:0]  out_flux_momentum_y,
  output logic signed [DATA_WIDTH-1:0]  out_flux_momentum_z,
  output logic signed [DATA_WIDTH-1:0]  out_flux_field_x,
  output logic signed [DATA_WIDTH-1:0]  out_flux_field_y,
  output logic                          out_flux_field_z,
  output logic signed [DATA_WIDTH-1:0]  out_flux_energy,
  output logic                          out_density_invalid
);

  import imhdy_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int XW     = 2 * W + 2;
  localparam int N_PROD = 14;
  localparam int N_DIV  = 11;
  localparam int N_POST = 8;

  // Product slots.
  localparam int P_MXMX = 0;
  localparam int P_MYMY = 1;
  localparam int P_MZMZ = 2;
  localparam int P_MXMZ = 3;
  localparam int P_MYMZ = 4;
  localparam int P_BXMZ = 5;
  localparam int P_BZMX = 6;
  localparam int P_BYMZ = 7;
  localparam int P_BZMY = 8;
  localparam int P_BXBX = 9;
  localparam int P_BYBY = 10;
  localparam int P_BZBZ = 11;
  localparam int P_BXBZ = 12;
  localparam int P_BYBZ = 13;

  // Quotient slots.
  localparam int Q_KE   = 0;
  localparam int Q_MXMZ = 1;
  localparam int Q_MYMZ = 2;
  localparam int Q_MZMZ = 3;
  localparam int Q_BXMZ = 4;
  localparam int Q_BZMX = 5;
  localparam int Q_BYMZ = 6;
  localparam int Q_BZMY = 7;
  localparam int Q_VX   = 8;
  localparam int Q_VY   = 9;
  localparam int Q_VZ   = 10;

  localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] ONE_X  = {{(XW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    logic           neg;
    logic [2*W-1:0] mag;
  } raw_t;

  typedef struct packed {
    logic                     vld;
    logic                     inv;
    word_t                    gm1;
    word_t                    rho;
    word_t                    mx;
    word_t                    my;
    word_t                    mz;
    word_t                    bx;
    word_t                    by;
    word_t                    bz;
    word_t                    e;
    raw_t  [N_PROD-1:0]       raw;
    word_t [N_PROD-1:0]       prod;
    word_t                    ksum;
    word_t                    mg;
  } pre_t;

  typedef struct packed {
    logic  inv;
    word_t e;
    word_t mg;
    word_t gm1;
    word_t bx;
    word_t by;
    word_t bz;
    word_t mz;
    word_t bxbz;
    word_t bybz;
    word_t bzbz;
  } side_t;

  typedef struct packed {
    logic  vld;
    logic  inv;
    word_t e;
    word_t mg;
    word_t gm1;
    word_t bz;
    word_t mz;
    word_t bzbz;
    word_t q3;
    word_t vz;
    word_t dd;
    word_t p;
    word_t t;
    word_t ps;
    word_t es;
    word_t bzt;
    word_t esvz;
    word_t x0;
    word_t x1;
    word_t x2;
    word_t f1;
    word_t f2;
    word_t f3;
    word_t f4;
    word_t f5;
    word_t f7;
    raw_t  r0;
    raw_t  r1;
    raw_t  r2;
  } ctx_t;

  // Saturating arithmetic on the signed word.
  function automatic word_t sat(input logic signed [XW-1:0] v);
    word_t res;
    if (v > VMAX_X) begin
      res = VMAX_X[W-1:0];
    end else if (v < VMIN_X) begin
      res = VMIN_X[W-1:0];
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [XW-1:0] ext(input word_t a);
    return {{(XW-W){a[W-1]}}, a};
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    return sat(ext(a) + ext(b));
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    return sat(ext(a) - ext(b));
  endfunction

  // Halving truncates toward zero.
  function automatic word_t half(input word_t x);
    logic [W-1:0] m;
    logic [W-1:0] h;
    m = x[W-1] ? (~x + 1'b1) : x;
    h = m >> 1;
    return x[W-1] ? (~h + 1'b1) : h;
  endfunction

  // Full product of magnitudes; the sign travels beside it.
  function automatic raw_t mul(input word_t a, input word_t b);
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    raw_t         r;
    ma    = a[W-1] ? (~a + 1'b1) : a;
    mb    = b[W-1] ? (~b + 1'b1) : b;
    r.neg = a[W-1] ^ b[W-1];
    r.mag = (2*W)'(ma) * (2*W)'(mb);
    return r;
  endfunction

  function automatic word_t fmt(input raw_t r);
    logic signed [XW-1:0] v;
    v = signed'({2'b00, r.mag >> F});
    if (r.neg) begin
      v = -v;
    end
    return sat(v);
  endfunction

  logic [GAMMA_W-1:0] gamma_r;
  logic               en;
  pre_t               a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [N_DIV-1:0][W-1:0] div_num;
  logic [N_DIV-1:0][W-1:0] div_quo;
  side_t              div_side_in;
  logic [$bits(side_t)-1:0] div_side_out;
  side_t              sd;
  logic               div_vld;
  ctx_t               st_r   [N_POST];
  ctx_t               st_nxt [N_POST];

  logic  out_valid_r;
  word_t out_flux_mass_r, out_flux_momentum_x_r, out_flux_momentum_y_r;
  word_t out_flux_momentum_z_r, out_flux_field_x_r, out_flux_field_y_r;
  word_t out_flux_energy_r;
  logic  out_density_invalid_r;

  // The whole pipeline moves unless a finished word is held at the output.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Gamma register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
    end else if (cfg_valid) begin
      gamma_r <= cfg_data;
    end
  end

  // Front stages: capture, multiply, format products, sum squares.
  always_comb begin
    a_nxt      = a_r;
    a_nxt.vld  = in_valid;
    a_nxt.inv  = in_density[W-1] || (in_density == '0);
    a_nxt.gm1  = sat(signed'({{(XW-GAMMA_W){1'b0}}, gamma_r}) - ONE_X);
    a_nxt.rho  = in_density;
    a_nxt.mx   = in_momentum_x;
    a_nxt.my   = in_momentum_y;
    a_nxt.mz   = in_momentum_z;
    a_nxt.bx   = in_field_x;
    a_nxt.by   = in_field_y;
    a_nxt.bz   = in_field_z;
    a_nxt.e    = in_total_energy;

    b_nxt = a_r;
    b_nxt.raw[P_MXMX] = mul(a_r.mx, a_r.mx);
    b_nxt.raw[P_MYMY] = mul(a_r.my, a_r.my);
    b_nxt.raw[P_MZMZ] = mul(a_r.mz, a_r.mz);
    b_nxt.raw[P_MXMZ] = mul(a_r.mx, a_r.mz);
    b_nxt.raw[P_MYMZ] = mul(a_r.my, a_r.mz);
    b_nxt.raw[P_BXMZ] = mul(a_r.bx, a_r.mz);
    b_nxt.raw[P_BZMX] = mul(a_r.bz, a_r.mx);
    b_nxt.raw[P_BYMZ] = mul(a_r.by, a_r.mz);
    b_nxt.raw[P_BZMY] = mul(a_r.bz, a_r.my);
    b_nxt.raw[P_BXBX] = mul(a_r.bx, a_r.bx);
    b_nxt.raw[P_BYBY] = mul(a_r.by, a_r.by);
    b_nxt.raw[P_BZBZ] = mul(a_r.bz, a_r.bz);
    b_nxt.raw[P_BXBZ] = mul(a_r.bx, a_r.bz);
    b_nxt.raw[P_BYBZ] = mul(a_r.by, a_r.bz);

    c_nxt = b_r;
    for (int i = 0; i < N_PROD; i++) begin
      c_nxt.prod[i] = fmt(b_r.raw[i]);
    end

    d_nxt      = c_r;
    d_nxt.ksum = sadd(sadd(c_r.prod[P_MXMX], c_r.prod[P_MYMY]), c_r.prod[P_MZMZ]);
    d_nxt.mg   = half(sadd(sadd(c_r.prod[P_BXBX], c_r.prod[P_BYBY]), c_r.prod[P_BZBZ]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
      c_r.vld <= 1'b0;
      d_r.vld <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  // Divisions by density, with the remaining operands carried alongside.
  always_comb begin
    div_num[Q_KE]   = d_r.ksum;
    div_num[Q_MXMZ] = d_r.prod[P_MXMZ];
    div_num[Q_MYMZ] = d_r.prod[P_MYMZ];
    div_num[Q_MZMZ] = d_r.prod[P_MZMZ];
    div_num[Q_BXMZ] = d_r.prod[P_BXMZ];
    div_num[Q_BZMX] = d_r.prod[P_BZMX];
    div_num[Q_BYMZ] = d_r.prod[P_BYMZ];
    div_num[Q_BZMY] = d_r.prod[P_BZMY];
    div_num[Q_VX]   = d_r.mx;
    div_num[Q_VY]   = d_r.my;
    div_num[Q_VZ]   = d_r.mz;
    div_side_in.inv  = d_r.inv;
    div_side_in.e    = d_r.e;
    div_side_in.mg   = d_r.mg;
    div_side_in.gm1  = d_r.gm1;
    div_side_in.bx   = d_r.bx;
    div_side_in.by   = d_r.by;
    div_side_in.bz   = d_r.bz;
    div_side_in.mz   = d_r.mz;
    div_side_in.bxbz = d_r.prod[P_BXBZ];
    div_side_in.bybz = d_r.prod[P_BYBZ];
    div_side_in.bzbz = d_r.prod[P_BZBZ];
  end

  imhdy_div #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (F),
    .LANES      (N_DIV),
    .SIDE_W     ($bits(side_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_r.vld),
    .in_num   (div_num),
    .in_den   (d_r.rho),
    .in_side  (div_side_in),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side_out)
  );

  assign sd = side_t'(div_side_out);

  // Back stages: pressure, induction terms and energy flux.
  always_comb begin
    // Kinetic energy, pressure operand and the simple differences.
    st_nxt[0]      = st_r[0];
    st_nxt[0].vld  = div_vld;
    st_nxt[0].inv  = sd.inv;
    st_nxt[0].e    = sd.e;
    st_nxt[0].mg   = sd.mg;
    st_nxt[0].gm1  = sd.gm1;
    st_nxt[0].bz   = sd.bz;
    st_nxt[0].mz   = sd.mz;
    st_nxt[0].bzbz = sd.bzbz;
    st_nxt[0].q3   = div_quo[Q_MZMZ];
    st_nxt[0].vz   = div_quo[Q_VZ];
    st_nxt[0].dd   = ssub(ssub(sd.e, half(div_quo[Q_KE])), sd.mg);
    st_nxt[0].f1   = ssub(div_quo[Q_MXMZ], sd.bxbz);
    st_nxt[0].f2   = ssub(div_quo[Q_MYMZ], sd.bybz);
    st_nxt[0].f4   = ssub(div_quo[Q_BXMZ], div_quo[Q_BZMX]);
    st_nxt[0].f5   = ssub(div_quo[Q_BYMZ], div_quo[Q_BZMY]);
    st_nxt[0].r0   = mul(sd.bx, div_quo[Q_VX]);
    st_nxt[0].r1   = mul(div_quo[Q_VY], sd.by);
    st_nxt[0].r2   = mul(div_quo[Q_VZ], sd.bz);

    // Gas pressure product; field-velocity terms formatted.
    st_nxt[1]    = st_r[0];
    st_nxt[1].x0 = fmt(st_r[0].r0);
    st_nxt[1].x1 = fmt(st_r[0].r1);
    st_nxt[1].x2 = fmt(st_r[0].r2);
    st_nxt[1].r0 = mul(st_r[0].gm1, st_r[0].dd);

    st_nxt[2]   = st_r[1];
    st_nxt[2].p = fmt(st_r[1].r0);
    st_nxt[2].t = sadd(sadd(st_r[1].x0, st_r[1].x1), st_r[1].x2);

    // Total pressure, then the magnetic part of the energy flux.
    st_nxt[3]    = st_r[2];
    st_nxt[3].ps = sadd(st_r[2].p, st_r[2].mg);
    st_nxt[3].r0 = mul(st_r[2].bz, st_r[2].t);

    st_nxt[4]     = st_r[3];
    st_nxt[4].f3  = ssub(sadd(st_r[3].q3, st_r[3].ps), st_r[3].bzbz);
    st_nxt[4].es  = sadd(st_r[3].e, st_r[3].ps);
    st_nxt[4].bzt = fmt(st_r[3].r0);

    st_nxt[5]    = st_r[4];
    st_nxt[5].r0 = mul(st_r[4].es, st_r[4].vz);

    st_nxt[6]      = st_r[5];
    st_nxt[6].esvz = fmt(st_r[5].r0);

    st_nxt[7]    = st_r[6];
    st_nxt[7].f7 = ssub(st_r[6].esvz, st_r[6].bzt);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_POST; k++) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Output word register; an invalid density forces every flux to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_r[N_POST-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_density_invalid_r <= st_r[N_POST-1].inv;
      out_flux_mass_r       <= st_r[N_POST-1].inv ? '0 : st_r[N_POST-1].mz;
      out_flux_momentum_x_r <= st_r[N_POST-1].inv ? '0 : st_r[N_POST-1].f1;
      out_flux_momentum_y_r <= st_r[N_POST-1].inv ? '0 : st_r[N_POST-1].f2;
      out_flux_momentum_z_r <= st_r[N_POST-1].inv ? '0 : st_r[N_POST-1].f3;
      out_flux_field_x_r    <= st_r[N_POST-1].inv ? '0 : st_r[N_POST-1].f4;
      out_flux_field_y_r    <= st_r[N_POST-1].inv ? '0 : st_r[N_POST-1].f5;
      out_flux_energy_r     <= st_r[N_POST-1].inv ? '0 : st_r[N_POST-1].f7;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_flux_mass       = out_flux_mass_r;
  assign out_flux_momentum_x = out_flux_momentum_x_r;
  assign out_flux_momentum_y = out_flux_momentum_y_r;
  assign out_flux_momentum_z = out_flux_momentum_z_r;
  assign out_flux_field_x    = out_flux_field_x_r;
  assign out_flux_field_y    = out_flux_field_y_r;
  assign out_flux_field_z    = 1'b0;
  assign out_flux_energy     = out_flux_energy_r;
  assign out_density_invalid = out_density_invalid_r;

  // An invalid density yields an all-zero word.
  a_inv_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_density_invalid |->
      out_flux_mass == '0 && out_flux_momentum_x == '0 && out_flux_momentum_y == '0 &&
      out_flux_momentum_z == '0 && out_flux_field_x == '0 && out_flux_field_y == '0 &&
      out_flux_energy == '0)
    else $error("invalid density produced a non-zero flux");

  // A stalled pipeline keeps its last stage in place.
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(st_r[N_POST-1].vld) && $stable(div_vld))
    else $error("pipeline moved during a stall");

  // No word is presented straight out of reset.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
